@@ rtl/core/tcag_pkg.sv @@
package tcag_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Fixed field widths
    localparam int KDIM_W  = 4;
    localparam int NIB_W   = 4;
    localparam int PAIR_W  = 8;
    localparam int PAD_W   = 8;
    localparam int LIMIT_W = 13;
    localparam int TAP_W   = 6;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_ROWS   = 3'd0,
        REG_KERNEL_COLS   = 3'd1,
        REG_STRIDE_PAIR   = 3'd2,
        REG_DILATION_PAIR = 3'd3,
        REG_PAD_TOP_ROWS  = 3'd4,
        REG_PAD_LEFT_COLS = 3'd5,
        REG_IN_ROWS       = 3'd6,
        REG_IN_COLS       = 3'd7
    } cfg_idx_t;

    // Programmed configuration, shared by front and back
    typedef struct packed {
        logic [KDIM_W-1:0]  kernel_rows;
        logic [KDIM_W-1:0]  kernel_cols;
        logic [PAIR_W-1:0]  stride_pair;
        logic [PAIR_W-1:0]  dilation_pair;
        logic [PAD_W-1:0]   pad_top_rows;
        logic [PAD_W-1:0]   pad_left_cols;
        logic [LIMIT_W-1:0] in_rows;
        logic [LIMIT_W-1:0] in_cols;
    } cfg_t;

    // Dilation split into whole strides and a remainder
    typedef struct packed {
        logic [NIB_W-1:0] dq;
        logic [NIB_W-1:0] dr;
    } dil_step_t;

    // A zero stride or dilation nibble acts as one
    function automatic logic [NIB_W-1:0] nib_or_one(input logic [NIB_W-1:0] v);
        return (v == '0) ? NIB_W'(1) : v;
    endfunction

endpackage

@@ rtl/core/tcag_fifo.sv @@
module tcag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + AW'(1));
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + AW'(1));
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNTW'(count_reg + CNTW'(1));
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNTW'(count_reg - CNTW'(1));
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/tcag_front.sv @@
module tcag_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcag_pkg::cfg_t         cfg,
    input  logic                   push,
    output logic                   full,
    input  logic [COORD_BITS-1:0]  out_row,
    input  logic [COORD_BITS-1:0]  out_col,
    output logic                   item_valid,
    input  logic                   item_ready,
    output logic [((COORD_BITS > tcag_pkg::PAD_W) ? COORD_BITS : tcag_pkg::PAD_W):0] item_q [2],
    output logic [tcag_pkg::NIB_W-1:0] item_r [2],
    output tcag_pkg::dil_step_t    item_step [2]
);

    localparam int NIB_W = tcag_pkg::NIB_W;
    localparam int YW    = ((COORD_BITS > tcag_pkg::PAD_W) ? COORD_BITS : tcag_pkg::PAD_W) + 1;
    localparam int RW    = YW + 1;
    localparam int PW    = YW + RW;
    localparam int DPW   = NIB_W + RW;
    localparam int RRW   = NIB_W + 1;
    localparam logic [RW-1:0] RONE = RW'(1) << YW;

    // Reciprocal of the stride scaled by 2^YW; quotient estimate is low by at most one
    function automatic logic [RW-1:0] recip_of(input logic [NIB_W-1:0] s);
        logic [RW-1:0] v;
        case (s)
            4'd2:    v = RW'(RONE / 2);
            4'd3:    v = RW'(RONE / 3);
            4'd4:    v = RW'(RONE / 4);
            4'd5:    v = RW'(RONE / 5);
            4'd6:    v = RW'(RONE / 6);
            4'd7:    v = RW'(RONE / 7);
            4'd8:    v = RW'(RONE / 8);
            4'd9:    v = RW'(RONE / 9);
            4'd10:   v = RW'(RONE / 10);
            4'd11:   v = RW'(RONE / 11);
            4'd12:   v = RW'(RONE / 12);
            4'd13:   v = RW'(RONE / 13);
            4'd14:   v = RW'(RONE / 14);
            4'd15:   v = RW'(RONE / 15);
            default: v = RONE;
        endcase
        return v;
    endfunction

    logic [COORD_BITS-1:0]     pos [2];
    logic [tcag_pkg::PAD_W-1:0] pad [2];
    logic [NIB_W-1:0]          str [2];
    logic [NIB_W-1:0]          dil [2];
    logic                      adv;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic                      s3_valid_reg;

    assign pos[0] = out_row;
    assign pos[1] = out_col;
    assign pad[0] = cfg.pad_top_rows;
    assign pad[1] = cfg.pad_left_cols;
    assign str[0] = tcag_pkg::nib_or_one(cfg.stride_pair[7:4]);
    assign str[1] = tcag_pkg::nib_or_one(cfg.stride_pair[3:0]);
    assign dil[0] = tcag_pkg::nib_or_one(cfg.dilation_pair[7:4]);
    assign dil[1] = tcag_pkg::nib_or_one(cfg.dilation_pair[3:0]);

    // Whole pipeline moves together; it holds only when the last stage cannot drain
    assign adv        = !(s3_valid_reg && !item_ready);
    assign full       = !adv;
    assign item_valid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Per axis: position = coord + pad, then divide position and dilation by stride
    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        logic [YW-1:0]    s1_y_reg;
        logic [YW-1:0]    s2_y_reg;
        logic [PW-1:0]    s2_pr_reg;
        logic [DPW-1:0]   s2_dpr_reg;
        logic [YW-1:0]    s3_q_reg;
        logic [RRW-1:0]   s3_r_reg;
        logic [NIB_W-1:0] s3_dq_reg;
        logic [RRW-1:0]   s3_dr_reg;
        logic [RW-1:0]    recip;
        logic [YW-1:0]    q_est;
        logic [NIB_W-1:0] dq_est;
        logic             r_over;
        logic             dr_over;

        assign recip  = recip_of(str[a]);
        assign q_est  = YW'(s2_pr_reg >> YW);
        assign dq_est = NIB_W'(s2_dpr_reg >> YW);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_y_reg   <= YW'(pos[a]) + YW'(pad[a]);
                s2_y_reg   <= s1_y_reg;
                s2_pr_reg  <= PW'(s1_y_reg) * PW'(recip);
                s2_dpr_reg <= DPW'(dil[a]) * DPW'(recip);
                s3_q_reg   <= q_est;
                s3_r_reg   <= RRW'(s2_y_reg) - RRW'(q_est) * RRW'(str[a]);
                s3_dq_reg  <= dq_est;
                s3_dr_reg  <= RRW'(dil[a]) - RRW'(dq_est) * RRW'(str[a]);
            end
        end

        // One-step correction of the estimates
        assign r_over  = (s3_r_reg >= RRW'(str[a]));
        assign dr_over = (s3_dr_reg >= RRW'(str[a]));

        assign item_q[a] = r_over ? YW'(s3_q_reg + YW'(1)) : s3_q_reg;
        assign item_r[a] = r_over ? NIB_W'(s3_r_reg - RRW'(str[a])) : NIB_W'(s3_r_reg);
        assign item_step[a].dq = dr_over ? NIB_W'(s3_dq_reg + NIB_W'(1)) : s3_dq_reg;
        assign item_step[a].dr = dr_over ? NIB_W'(s3_dr_reg - RRW'(str[a])) : NIB_W'(s3_dr_reg);
    end

endmodule

@@ rtl/core/tcag_back.sv @@
module tcag_back #(
    parameter int MAX_KERNEL_DIM = 8,
    parameter int COORD_BITS     = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcag_pkg::cfg_t         cfg,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  logic [((COORD_BITS > tcag_pkg::PAD_W) ? COORD_BITS : tcag_pkg::PAD_W):0] item_q [2],
    input  logic [tcag_pkg::NIB_W-1:0] item_r [2],
    input  tcag_pkg::dil_step_t    item_step [2],
    output logic                   res_push,
    input  logic                   res_full,
    output logic [COORD_BITS-1:0]  src_row,
    output logic [COORD_BITS-1:0]  src_col,
    output logic                   hit,
    output logic [tcag_pkg::TAP_W-1:0] tap_index,
    output logic                   last_tap
);

    localparam int NIB_W  = tcag_pkg::NIB_W;
    localparam int KDIM_W = tcag_pkg::KDIM_W;
    localparam int TAP_W  = tcag_pkg::TAP_W;
    localparam int YW     = ((COORD_BITS > tcag_pkg::PAD_W) ? COORD_BITS : tcag_pkg::PAD_W) + 1;
    localparam int QW     = YW + 1;
    localparam int CW     = (YW > tcag_pkg::LIMIT_W) ? YW : tcag_pkg::LIMIT_W;
    localparam int KW     = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;

    logic [KDIM_W-1:0] kr_c;
    logic [KDIM_W-1:0] kc_c;
    logic [NIB_W-1:0]  str [2];
    logic [tcag_pkg::LIMIT_W-1:0] lim [2];

    logic              busy_reg;
    logic [KW-1:0]     ky_reg;
    logic [KW-1:0]     kx_reg;
    logic [TAP_W-1:0]  tap_reg;

    // Axis 0 is the row walk, axis 1 the column walk
    logic [QW-1:0]       q_reg [2];
    logic [NIB_W-1:0]    r_reg [2];
    logic [QW-1:0]       cq0_reg;
    logic [NIB_W-1:0]    cr0_reg;
    tcag_pkg::dil_step_t step_reg [2];

    logic [QW-1:0]    q_next [2];
    logic [NIB_W-1:0] r_next [2];
    logic             ax_hit [2];

    logic emit;
    logic row_end;
    logic col_end;
    logic last_emit;
    logic load;

    // Clamp kernel dimensions to 1..MAX_KERNEL_DIM
    assign kr_c = (cfg.kernel_rows == '0) ? KDIM_W'(1) :
                  (cfg.kernel_rows > KDIM_W'(MAX_KERNEL_DIM)) ? KDIM_W'(MAX_KERNEL_DIM) :
                  cfg.kernel_rows;
    assign kc_c = (cfg.kernel_cols == '0) ? KDIM_W'(1) :
                  (cfg.kernel_cols > KDIM_W'(MAX_KERNEL_DIM)) ? KDIM_W'(MAX_KERNEL_DIM) :
                  cfg.kernel_cols;

    assign str[0] = tcag_pkg::nib_or_one(cfg.stride_pair[7:4]);
    assign str[1] = tcag_pkg::nib_or_one(cfg.stride_pair[3:0]);
    assign lim[0] = cfg.in_rows;
    assign lim[1] = cfg.in_cols;

    // Tap sequencing
    assign emit      = busy_reg && !res_full;
    assign row_end   = (KDIM_W'(ky_reg) == KDIM_W'(kr_c - KDIM_W'(1)));
    assign col_end   = (KDIM_W'(kx_reg) == KDIM_W'(kc_c - KDIM_W'(1)));
    assign last_emit = emit && row_end && col_end;
    assign load      = item_valid && (!busy_reg || last_emit);
    assign item_pop  = load;

    // Step each axis back by one dilation; test for a hit
    for (genvar a = 0; a < 2; a++)
    begin : g_step
        logic [NIB_W:0] rdiff;

        assign rdiff     = {1'b0, r_reg[a]} - {1'b0, step_reg[a].dr};
        assign r_next[a] = rdiff[NIB_W] ? NIB_W'(rdiff + {1'b0, str[a]}) : rdiff[NIB_W-1:0];
        assign q_next[a] = QW'(q_reg[a] - QW'(step_reg[a].dq) - QW'(rdiff[NIB_W]));
        assign ax_hit[a] = !q_reg[a][QW-1] && (r_reg[a] == '0) &&
                           (CW'(q_reg[a][YW-1:0]) < CW'(lim[a]));
    end

    // Result beat
    assign res_push  = busy_reg;
    assign hit       = ax_hit[0] && ax_hit[1];
    assign src_row   = hit ? q_reg[0][COORD_BITS-1:0] : '0;
    assign src_col   = hit ? q_reg[1][COORD_BITS-1:0] : '0;
    assign tap_index = tap_reg;
    assign last_tap  = row_end && col_end;

    // Walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ky_reg   <= '0;
            kx_reg   <= '0;
            tap_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            ky_reg   <= '0;
            kx_reg   <= '0;
            tap_reg  <= '0;
        end
        else if (emit)
        begin
            if (row_end && col_end)
            begin
                busy_reg <= 1'b0;
            end
            else if (col_end)
            begin
                kx_reg <= '0;
                ky_reg <= KW'(ky_reg + KW'(1));
            end
            else
            begin
                kx_reg <= KW'(kx_reg + KW'(1));
            end
            tap_reg <= TAP_W'(tap_reg + TAP_W'(1));
        end
    end

    // Quotient/remainder tracking of both axes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg[0]    <= QW'(item_q[0]);
            r_reg[0]    <= item_r[0];
            q_reg[1]    <= QW'(item_q[1]);
            r_reg[1]    <= item_r[1];
            cq0_reg     <= QW'(item_q[1]);
            cr0_reg     <= item_r[1];
            step_reg[0] <= item_step[0];
            step_reg[1] <= item_step[1];
        end
        else if (emit && !(row_end && col_end))
        begin
            if (col_end)
            begin
                q_reg[0] <= q_next[0];
                r_reg[0] <= r_next[0];
                q_reg[1] <= cq0_reg;
                r_reg[1] <= cr0_reg;
            end
            else
            begin
                q_reg[1] <= q_next[1];
                r_reg[1] <= r_next[1];
            end
        end
    end

    // The final tap of a pixel carries the last tap number of the kernel
    assert property (@(posedge clk) disable iff (!rst_n)
        last_emit |-> (tap_reg == TAP_W'({4'b0, kr_c} * {4'b0, kc_c} - 8'd1)))
        else $error("last tap at wrong tap number");

    // A walk that has not reached its final tap stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last_emit) |=> busy_reg)
        else $error("walk ended early");

    // Each kernel row starts at the column position of the pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (kx_reg == '0)) |-> ((q_reg[1] == cq0_reg) && (r_reg[1] == cr0_reg)))
        else $error("column walk did not restart");

    // A stalled result keeps the walk in place
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && res_full) |=> ($stable(tap_reg) && $stable(ky_reg) && $stable(kx_reg)))
        else $error("walk moved while stalled");

endmodule

@@ rtl/core/transposed_conv_tap_address_gen.sv @@
// Transposed-convolution tap address generator.
//
// Input channel: one beat is an output pixel (out_row, out_col), taken when
// push is high and full is low. Result channel: one beat per kernel tap,
// walked row by row; the oldest beat sits on src_row/src_col/hit/tap_index/
// last_tap while empty is low and is taken when pop is high. last_tap marks
// the final tap of a pixel.
// Configuration: cfg_we writes cfg_data into register cfg_index on the edge;
// write only while no pixel is in flight.
// Path: a pixel beat passes the three-stage divide pipeline, the pixel queue,
// the tap walker and the output queue. Throughput: one tap per cycle while
// the output queue is not full; a pixel gives kernel_rows*kernel_cols taps
// (nine for a 3x3 kernel), and the tap walker sets this rate. The next
// pixel's divide runs in the front while the walker works on the current one.
// Reset clears the queues and the walker, and loads the register defaults
// (1x1 kernel, unit stride and dilation, no padding, 1x1 input).
// When pop is held low the two-entry output queue fills, the walker holds,
// then the pixel queue and the front fill, and full rises.
module transposed_conv_tap_address_gen #(
    parameter int MAX_KERNEL_DIM = 8,
    parameter int COORD_BITS     = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tcag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [COORD_BITS-1:0]             out_row,
    input  logic [COORD_BITS-1:0]             out_col,
    output logic                              empty,
    input  logic                              pop,
    output logic [COORD_BITS-1:0]             src_row,
    output logic [COORD_BITS-1:0]             src_col,
    output logic                              hit,
    output logic [tcag_pkg::TAP_W-1:0]        tap_index,
    output logic                              last_tap
);

    localparam int NIB_W = tcag_pkg::NIB_W;
    localparam int TAP_W = tcag_pkg::TAP_W;
    localparam int YW    = ((COORD_BITS > tcag_pkg::PAD_W) ? COORD_BITS : tcag_pkg::PAD_W) + 1;
    localparam int SW    = $bits(tcag_pkg::dil_step_t);
    localparam int MW    = 2 * YW + 2 * NIB_W + 2 * SW;
    localparam int OW    = 2 * COORD_BITS + 1 + TAP_W + 1;

    tcag_pkg::cfg_t cfg_reg;

    logic                item_valid;
    logic                item_ready;
    logic [YW-1:0]       f_q [2];
    logic [NIB_W-1:0]    f_r [2];
    tcag_pkg::dil_step_t f_step [2];

    logic                mid_full;
    logic                mid_empty;
    logic                mid_pop;
    logic [MW-1:0]       mid_wdata;
    logic [MW-1:0]       mid_rdata;
    logic [YW-1:0]       b_q [2];
    logic [NIB_W-1:0]    b_r [2];
    tcag_pkg::dil_step_t b_step [2];

    logic                   res_push;
    logic                   res_full;
    logic [COORD_BITS-1:0]  r_src_row;
    logic [COORD_BITS-1:0]  r_src_col;
    logic                   r_hit;
    logic [TAP_W-1:0]       r_tap;
    logic                   r_last;
    logic [OW-1:0]          out_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_rows   <= 4'd1;
            cfg_reg.kernel_cols   <= 4'd1;
            cfg_reg.stride_pair   <= 8'd17;
            cfg_reg.dilation_pair <= 8'd17;
            cfg_reg.pad_top_rows  <= 8'd0;
            cfg_reg.pad_left_cols <= 8'd0;
            cfg_reg.in_rows       <= 13'd1;
            cfg_reg.in_cols       <= 13'd1;
        end
        else if (cfg_we)
        begin
            case (tcag_pkg::cfg_idx_t'(cfg_index))
                tcag_pkg::REG_KERNEL_ROWS:   cfg_reg.kernel_rows   <= cfg_data[3:0];
                tcag_pkg::REG_KERNEL_COLS:   cfg_reg.kernel_cols   <= cfg_data[3:0];
                tcag_pkg::REG_STRIDE_PAIR:   cfg_reg.stride_pair   <= cfg_data[7:0];
                tcag_pkg::REG_DILATION_PAIR: cfg_reg.dilation_pair <= cfg_data[7:0];
                tcag_pkg::REG_PAD_TOP_ROWS:  cfg_reg.pad_top_rows  <= cfg_data[7:0];
                tcag_pkg::REG_PAD_LEFT_COLS: cfg_reg.pad_left_cols <= cfg_data[7:0];
                tcag_pkg::REG_IN_ROWS:       cfg_reg.in_rows       <= cfg_data[12:0];
                tcag_pkg::REG_IN_COLS:       cfg_reg.in_cols       <= cfg_data[12:0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Front: position add and stride divide
    tcag_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .out_row    (out_row),
        .out_col    (out_col),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_q     (f_q),
        .item_r     (f_r),
        .item_step  (f_step)
    );

    // Pixel queue between front and walker
    assign item_ready = !mid_full;
    assign mid_wdata  = {f_q[1], f_q[0], f_r[1], f_r[0], f_step[1], f_step[0]};
    assign {b_q[1], b_q[0], b_r[1], b_r[0], b_step[1], b_step[0]} = mid_rdata;

    tcag_fifo #(
        .WIDTH (MW),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_valid),
        .full  (mid_full),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_rdata)
    );

    // Back: tap walker
    tcag_back #(
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (!mid_empty),
        .item_pop   (mid_pop),
        .item_q     (b_q),
        .item_r     (b_r),
        .item_step  (b_step),
        .res_push   (res_push),
        .res_full   (res_full),
        .src_row    (r_src_row),
        .src_col    (r_src_col),
        .hit        (r_hit),
        .tap_index  (r_tap),
        .last_tap   (r_last)
    );

    // Output queue
    tcag_fifo #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata ({r_src_row, r_src_col, r_hit, r_tap, r_last}),
        .pop   (pop),
        .empty (empty),
        .rdata (out_rdata)
    );

    assign {src_row, src_col, hit, tap_index, last_tap} = out_rdata;

endmodule

@@ tb/testbench.sv @@
module testbench;

    localparam int COORD_BITS  = 12;
    localparam int MAX_KDIM    = 8;
    localparam int RUN_LIMIT   = 1000000;
    localparam int SETTLE_CYC  = 16;
    localparam int HOLD_CYC    = 400;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 34;
    localparam int FILL_ITEMS  = 40;

    localparam int TAP_W      = tcag_pkg::TAP_W;
    localparam int CFG_IDX_W  = tcag_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tcag_pkg::CFG_DATA_W;
    localparam int KDIM_W     = tcag_pkg::KDIM_W;
    localparam int NIB_W      = tcag_pkg::NIB_W;
    localparam int PAIR_W     = tcag_pkg::PAIR_W;
    localparam int PAD_W      = tcag_pkg::PAD_W;
    localparam int LIMIT_W    = tcag_pkg::LIMIT_W;

    typedef struct {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } pixel_t;

    typedef struct {
        logic [COORD_BITS-1:0] src_row;
        logic [COORD_BITS-1:0] src_col;
        logic                  hit;
        logic [TAP_W-1:0]      tap_index;
        logic                  last_tap;
    } tap_beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [COORD_BITS-1:0] out_row   = '0;
    logic [COORD_BITS-1:0] out_col   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [COORD_BITS-1:0] src_row;
    logic [COORD_BITS-1:0] src_col;
    logic                  hit;
    logic [TAP_W-1:0]      tap_index;
    logic                  last_tap;

    // Shadow of the programmed geometry
    tcag_pkg::cfg_t geom;

    pixel_t    pixel_backlog[$];
    tap_beat_t pending_taps[$];

    int unsigned cycle_count   = 0;
    int          fail_count    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          pixel_taken   = 1'b0;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;

    transposed_conv_tap_address_gen #(
        .MAX_KERNEL_DIM(MAX_KDIM),
        .COORD_BITS    (COORD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .out_row  (out_row),
        .out_col  (out_col),
        .empty    (empty),
        .pop      (pop),
        .src_row  (src_row),
        .src_col  (src_col),
        .hit      (hit),
        .tap_index(tap_index),
        .last_tap (last_tap)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Kernel size: zero acts as one, oversize saturates
    function automatic int eff_kdim(input logic [KDIM_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > MAX_KDIM) ? MAX_KDIM : int'(v);
    endfunction

    // Stride or dilation nibble: zero acts as one
    function automatic int eff_step(input logic [NIB_W-1:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    // One axis of a tap: hit test and source index
    function automatic bit resolve_axis(input int pos, input int pad, input int tap,
                                        input int dil, input int stride, input int limit,
                                        output logic [COORD_BITS-1:0] src);
        int y;
        y = pos + pad - tap * dil;
        src = '0;
        if (y < 0 || (y % stride) != 0 || (y / stride) >= limit)
            return 1'b0;
        src = COORD_BITS'(y / stride);
        return 1'b1;
    endfunction

    // Expand one output pixel into its tap beats, row by row
    task automatic walk_kernel_taps(input logic [COORD_BITS-1:0] row,
                                    input logic [COORD_BITS-1:0] col);
        int kr, kc, vstr, hstr, vdil, hdil;
        bit row_hit, col_hit;
        logic [COORD_BITS-1:0] sr, sc;
        tap_beat_t t;
        kr   = eff_kdim(geom.kernel_rows);
        kc   = eff_kdim(geom.kernel_cols);
        vstr = eff_step(geom.stride_pair[7:4]);
        hstr = eff_step(geom.stride_pair[3:0]);
        vdil = eff_step(geom.dilation_pair[7:4]);
        hdil = eff_step(geom.dilation_pair[3:0]);
        for (int ky = 0; ky < kr; ky++)
        begin
            row_hit = resolve_axis(int'(row), int'(geom.pad_top_rows), ky, vdil, vstr,
                                   int'(geom.in_rows), sr);
            for (int kx = 0; kx < kc; kx++)
            begin
                col_hit = resolve_axis(int'(col), int'(geom.pad_left_cols), kx, hdil, hstr,
                                       int'(geom.in_cols), sc);
                t.hit       = row_hit && col_hit;
                t.src_row   = t.hit ? sr : '0;
                t.src_col   = t.hit ? sc : '0;
                t.tap_index = TAP_W'(ky * kc + kx);
                t.last_tap  = (ky == kr - 1) && (kx == kc - 1);
                pending_taps.push_back(t);
            end
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Register write; shadow copy keeps the same masking as the hardware
    task automatic write_reg(input tcag_pkg::cfg_idx_t idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        case (idx)
            tcag_pkg::REG_KERNEL_ROWS:   geom.kernel_rows   = KDIM_W'(val);
            tcag_pkg::REG_KERNEL_COLS:   geom.kernel_cols   = KDIM_W'(val);
            tcag_pkg::REG_STRIDE_PAIR:   geom.stride_pair   = PAIR_W'(val);
            tcag_pkg::REG_DILATION_PAIR: geom.dilation_pair = PAIR_W'(val);
            tcag_pkg::REG_PAD_TOP_ROWS:  geom.pad_top_rows  = PAD_W'(val);
            tcag_pkg::REG_PAD_LEFT_COLS: geom.pad_left_cols = PAD_W'(val);
            tcag_pkg::REG_IN_ROWS:       geom.in_rows       = LIMIT_W'(val);
            tcag_pkg::REG_IN_COLS:       geom.in_cols       = LIMIT_W'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int kr, input int kc, input int strides,
                              input int dils, input int pad_t, input int pad_l,
                              input int rows, input int cols);
        write_reg(tcag_pkg::REG_KERNEL_ROWS, kr);
        write_reg(tcag_pkg::REG_KERNEL_COLS, kc);
        write_reg(tcag_pkg::REG_STRIDE_PAIR, strides);
        write_reg(tcag_pkg::REG_DILATION_PAIR, dils);
        write_reg(tcag_pkg::REG_PAD_TOP_ROWS, pad_t);
        write_reg(tcag_pkg::REG_PAD_LEFT_COLS, pad_l);
        write_reg(tcag_pkg::REG_IN_ROWS, rows);
        write_reg(tcag_pkg::REG_IN_COLS, cols);
    endtask

    function automatic int pick_extent();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 8191);
            1:       return 4096;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // Mostly small kernels and images, now and then the extremes
    task automatic randomize_config();
        int kr, kc, pad_t, pad_l;
        kr    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        kc    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        pad_t = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        pad_l = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        set_config(kr, kc, $urandom_range(0, 255), $urandom_range(0, 255),
                   pad_t, pad_l, pick_extent(), pick_extent());
    endtask

    task automatic queue_pixel(input int row, input int col);
        pixel_t p;
        p.row = COORD_BITS'(row);
        p.col = COORD_BITS'(col);
        pixel_backlog.push_back(p);
    endtask

    // Coordinates mostly inside the span that the taps can reach
    task automatic queue_random_pixel();
        int span_r, span_c;
        span_r = int'(geom.in_rows) * eff_step(geom.stride_pair[7:4])
                 + eff_kdim(geom.kernel_rows) * eff_step(geom.dilation_pair[7:4]);
        span_c = int'(geom.in_cols) * eff_step(geom.stride_pair[3:0])
                 + eff_kdim(geom.kernel_cols) * eff_step(geom.dilation_pair[3:0]);
        if (span_r > 4095)
            span_r = 4095;
        if (span_c > 4095)
            span_c = 4095;
        queue_pixel(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, span_r),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, span_c));
    endtask

    // Wait until every pixel is taken and every tap beat has come back
    task automatic drain();
        while (pixel_backlog.size() != 0 || pending_taps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Input side: hold a beat until taken, otherwise offer at random
    always @(negedge clk)
    begin
        if (rst_n && !(push && !pixel_taken))
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                out_row <= pixel_backlog[0].row;
                out_col <= pixel_backlog[0].col;
            end
            else
                push <= 1'b0;
        end
        pixel_taken = 1'b0;
    end

    // Result side: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYC;
            hold_request = 1'b0;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predict on each pixel beat, check each tap beat
    always @(posedge clk)
    begin
        tap_beat_t want;
        cycle_count++;
        if (rst_n && push && !full)
        begin
            walk_kernel_taps(out_row, out_col);
            void'(pixel_backlog.pop_front());
            pixel_taken = 1'b1;
        end
        if (rst_n && pop && !empty)
        begin
            if (pending_taps.size() == 0)
            begin
                $error("unexpected tap beat: tap_index %0d", tap_index);
                fail_count++;
            end
            else
            begin
                want = pending_taps.pop_front();
                check_field("src_row", want.src_row, src_row);
                check_field("src_col", want.src_col, src_col);
                check_field("hit", want.hit, hit);
                check_field("tap_index", want.tap_index, tap_index);
                check_field("last_tap", want.last_tap, last_tap);
            end
        end
    end

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        geom.kernel_rows   = 1;
        geom.kernel_cols   = 1;
        geom.stride_pair   = 8'h11;
        geom.dilation_pair = 8'h11;
        geom.pad_top_rows  = 0;
        geom.pad_left_cols = 0;
        geom.in_rows       = 1;
        geom.in_cols       = 1;
        send_idle_pct      = 9;
        recv_idle_pct      = 69;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: 1x1 kernel over a 1x1 image
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        drain();

        // Zero kernel rows, oversize kernel cols, zero strides and dilations,
        // full padding, source index beyond the coordinate width
        set_config(0, 15, 8'h00, 8'h00, 255, 255, 8191, 8191);
        queue_pixel(4095, 4095);
        queue_pixel(0, 0);
        queue_pixel(4095, 0);
        queue_pixel(2048, 1234);
        drain();

        // Largest kernel, widest strides and dilations, zero input height
        set_config(8, 8, 8'hFF, 8'hFF, 0, 0, 0, 4096);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        drain();

        // Saturated rows, zero cols, one zero nibble per pair, zero input width
        set_config(9, 0, 8'h0F, 8'hF0, 0, 255, 4096, 0);
        queue_pixel(4095, 15);
        queue_pixel(30, 0);
        drain();

        // Ordinary 3x3 case with mixed stride and dilation
        set_config(3, 3, 8'h21, 8'h12, 2, 1, 5, 7);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(2, 3);
        queue_pixel(5, 6);
        queue_pixel(9, 7);
        queue_pixel(10, 14);
        drain();

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase < RAND_PHASES / 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 69;
            end
            else if (phase < 2 * RAND_PHASES / 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            randomize_config();
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_pixel();
            drain();

            // Back-pressure: receiver holds off while the sender keeps offering
            if (phase == 3)
            begin
                randomize_config();
                send_idle_pct = 0;
                @(posedge clk);
                hold_request = 1'b1;
                for (int n = 0; n < FILL_ITEMS; n++)
                    queue_random_pixel();
                drain();
            end
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
